[hw/rtl/qspid_pkg.sv]
// ----------------------------------------------------------------------------
// qspid_pkg
// Shared types and constants for the quadrature speed PID block.
// ----------------------------------------------------------------------------
`default_nettype none
package qspid_pkg;
    localparam int FRAC_BITS = 16;

    localparam logic [2:0] REG_DIR    = 3'd0;
    localparam logic [2:0] REG_DIST   = 3'd1;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_SETPT  = 3'd3;
    localparam logic [2:0] REG_KP     = 3'd4;
    localparam logic [2:0] REG_KI     = 3'd5;
    localparam logic [2:0] REG_KD     = 3'd6;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SAMPLE,
        OP_DELTA,    // delta = count - baseline (wrapping), baseline <= count
        OP_MUL_DIST, // num = delta * dist
        OP_DIV_START,// begin num<<F / period
        OP_DIV_STEP, // one restoring step
        OP_SPEED,    // speed <= quotient, err
        OP_INTEG,    // num = err * period, integral increment
        OP_DERIV_NUM,// integral update, num = err - last_err
        OP_DERIV,    // deriv <= quotient
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_DRIVE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    function automatic logic signed [63:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 64'sd2147483647;
        if (v < -66'sd2147483648) return -64'sd2147483648;
        return v[63:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/qspid_ctrl.sv]
// ----------------------------------------------------------------------------
// qspid_ctrl
// Sequencer: walks the datapath through one item.
// ----------------------------------------------------------------------------
`default_nettype none
module qspid_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire                  i_tick,
    input  wire                  i_out_free,
    input  qspid_pkg::t_stat     i_stat,
    output qspid_pkg::t_cmd      o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);
    typedef enum logic [3:0] {
        S_IDLE, S_DELTA, S_MUL, S_DIV1, S_DIVS1, S_SPEED, S_INTEG, S_DNUM,
        S_DIV2, S_DIVS2, S_DERIV, S_MP, S_MI, S_MD, S_DRIVE, S_OUT
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) r_state <= i_tick ? S_DELTA : S_OUT;
                end
                S_DELTA: r_state <= S_MUL;
                S_MUL:   r_state <= S_DIV1;
                S_DIV1:  r_state <= S_DIVS1;
                S_DIVS1: if (i_stat.div_done) r_state <= S_SPEED;
                S_SPEED: r_state <= S_INTEG;
                S_INTEG: r_state <= S_DNUM;
                S_DNUM:  r_state <= S_DIV2;
                S_DIV2:  r_state <= S_DIVS2;
                S_DIVS2: if (i_stat.div_done) r_state <= S_DERIV;
                S_DERIV: r_state <= S_MP;
                S_MP:    r_state <= S_MI;
                S_MI:    r_state <= S_MD;
                S_MD:    r_state <= S_DRIVE;
                S_DRIVE: r_state <= S_OUT;
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.op = qspid_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE:  o_cmd.op = (i_start && !i_tick) ? qspid_pkg::OP_SAMPLE
                                                    : qspid_pkg::OP_NONE;
            S_DELTA: o_cmd.op = qspid_pkg::OP_DELTA;
            S_MUL:   o_cmd.op = qspid_pkg::OP_MUL_DIST;
            S_DIV1, S_DIV2: o_cmd.op = qspid_pkg::OP_DIV_START;
            S_DIVS1, S_DIVS2: o_cmd.op = qspid_pkg::OP_DIV_STEP;
            S_SPEED: o_cmd.op = qspid_pkg::OP_SPEED;
            S_INTEG: o_cmd.op = qspid_pkg::OP_INTEG;
            S_DNUM:  o_cmd.op = qspid_pkg::OP_DERIV_NUM;
            S_DERIV: o_cmd.op = qspid_pkg::OP_DERIV;
            S_MP:    o_cmd.op = qspid_pkg::OP_MUL_P;
            S_MI:    o_cmd.op = qspid_pkg::OP_MUL_I;
            S_MD:    o_cmd.op = qspid_pkg::OP_MUL_D;
            S_DRIVE: o_cmd.op = qspid_pkg::OP_DRIVE;
            default: o_cmd.op = qspid_pkg::OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1) |=> (r_state == S_DIVS1))
        else $error("divide start not followed by steps");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_free) |=> (r_state == S_OUT))
        else $error("left output wait while result pending");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("done outside idle");
endmodule
`default_nettype wire

[hw/rtl/qspid_dp.sv]
// ----------------------------------------------------------------------------
// qspid_dp
// Datapath: decoder, count, multipliers, serial divider, PID state.
// ----------------------------------------------------------------------------
`default_nettype none
module qspid_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  qspid_pkg::t_cmd   i_cmd,
    output qspid_pkg::t_stat  o_stat,
    input  wire               i_pa,
    input  wire               i_pb,
    input  wire               i_dir,
    input  wire  [31:0]       i_dist,
    input  wire  [31:0]       i_period,
    input  wire  signed [31:0] i_setpt,
    input  wire  signed [31:0] i_kp,
    input  wire  signed [31:0] i_ki,
    input  wire  signed [31:0] i_kd,
    output logic signed [31:0] o_drive,
    output logic signed [31:0] o_speed,
    output logic signed [31:0] o_count
);
    localparam int F = qspid_pkg::FRAC_BITS;

    logic [1:0]         r_phase;
    logic [31:0]        r_count, r_base;
    logic signed [31:0] r_integ, r_lerr, r_drive, r_speed, r_err, r_delta, r_deriv;
    logic signed [63:0] r_num;
    logic signed [65:0] r_acc;
    // divider: quotient of |num|<<F / period, 80-bit dividend (bit serial)
    logic [79:0]        r_dvd;
    logic [32:0]        r_rem;
    logic [6:0]         r_dcnt;
    logic               r_neg;
    logic [31:0]        r_per;

    logic [1:0]  w_cur, w_up, w_dn;
    logic [31:0] w_diff;
    logic [33:0] w_trial;
    logic [32:0] w_rsh;
    logic [63:0] w_mag;
    logic signed [63:0] w_prod;
    logic signed [32:0] w_err;
    logic signed [65:0] w_q;
    logic [79:0] w_quo;
    logic signed [63:0] w_err_sat, w_integ_sat, w_drive_sat;

    always_comb begin
        w_cur = {i_pa, i_pb};
        case (r_phase)
            2'd0: begin w_up = 2'd1; w_dn = 2'd2; end
            2'd1: begin w_up = 2'd3; w_dn = 2'd0; end
            2'd2: begin w_up = 2'd0; w_dn = 2'd3; end
            default: begin w_up = 2'd2; w_dn = 2'd1; end
        endcase
        w_diff = r_count - r_base;
        w_rsh  = {r_rem[31:0], r_dvd[79]};
        w_trial = {1'b0, w_rsh} - {2'b0, r_per};
        w_mag  = r_num[63] ? (64'd0 - r_num) : r_num;
        w_prod = 64'sd0;
        case (i_cmd.op)
            qspid_pkg::OP_MUL_DIST: w_prod = $signed(r_delta) * $signed({1'b0, i_dist});
            qspid_pkg::OP_MUL_P:    w_prod = r_err * i_kp;
            qspid_pkg::OP_MUL_I:    w_prod = r_integ * i_ki;
            qspid_pkg::OP_MUL_D:    w_prod = r_deriv * i_kd;
            default:                w_prod = 64'sd0;
        endcase
        // magnitude clamps to 2^31 when negative, 2^31-1 when positive
        w_quo = r_dvd;
        if (r_neg) begin
            if (w_quo > 80'h80000000) w_q = -66'sh80000000;
            else w_q = -$signed({2'b0, w_quo[63:0]});
        end else begin
            if (w_quo > 80'h7FFFFFFF) w_q = 66'sh7FFFFFFF;
            else w_q = $signed({2'b0, w_quo[63:0]});
        end
        w_err = $signed({i_setpt[31], i_setpt}) - $signed({w_q[31], w_q[31:0]});
        w_err_sat   = qspid_pkg::sat32({{33{w_err[32]}}, w_err});
        w_integ_sat = qspid_pkg::sat32($signed({{34{r_integ[31]}}, r_integ})
                      + $signed({{F+2{r_num[63]}}, r_num[63:F]}));
        w_drive_sat = qspid_pkg::sat32(r_acc >>> F);
    end

    // saturating 64-bit add into r_acc
    function automatic logic signed [65:0] sadd(input logic signed [65:0] a,
                                                input logic signed [63:0] b);
        logic signed [65:0] s;
        s = a + b;
        if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF) s = 66'sh0_7FFF_FFFF_FFFF_FFFF;
        if (s < -66'sh0_8000_0000_0000_0000) s = -66'sh0_8000_0000_0000_0000;
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0; r_count <= '0; r_base <= '0;
            r_integ <= '0; r_lerr <= '0; r_drive <= '0; r_speed <= '0;
            r_dcnt  <= '0;
        end else begin
            case (i_cmd.op)
                qspid_pkg::OP_SAMPLE: begin
                    if (w_cur == w_up)      r_count <= i_dir ? r_count - 1 : r_count + 1;
                    else if (w_cur == w_dn) r_count <= i_dir ? r_count + 1 : r_count - 1;
                    r_phase <= w_cur;
                end
                qspid_pkg::OP_DELTA: begin
                    r_delta <= w_diff;
                    r_base  <= r_count;
                end
                qspid_pkg::OP_MUL_DIST: r_num <= w_prod;
                qspid_pkg::OP_DIV_START: begin
                    r_neg  <= r_num[63];
                    r_dvd  <= {w_mag, {F{1'b0}}};
                    r_rem  <= '0;
                    r_per  <= (i_period == 32'd0) ? 32'd1 : i_period;
                    r_dcnt <= 7'd80;
                end
                qspid_pkg::OP_DIV_STEP: begin
                    if (r_dcnt != 7'd0) begin
                        r_dcnt <= r_dcnt - 7'd1;
                        if (!w_trial[33]) begin
                            r_rem <= w_trial[32:0];
                            r_dvd <= {r_dvd[78:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_dvd <= {r_dvd[78:0], 1'b0};
                        end
                    end
                end
                qspid_pkg::OP_SPEED: begin
                    r_speed <= w_q[31:0];
                    r_err   <= w_err_sat[31:0];
                end
                qspid_pkg::OP_INTEG: begin
                    r_num   <= r_err * $signed({1'b0, r_per});
                end
                qspid_pkg::OP_DERIV_NUM: begin
                    r_integ <= w_integ_sat[31:0];
                    r_num   <= $signed({{32{r_err[31]}}, r_err})
                               - $signed({{32{r_lerr[31]}}, r_lerr});
                    r_acc   <= '0;
                end
                qspid_pkg::OP_DERIV: begin
                    r_deriv <= w_q[31:0];
                    r_lerr  <= r_err;
                end
                qspid_pkg::OP_MUL_P, qspid_pkg::OP_MUL_I, qspid_pkg::OP_MUL_D:
                    r_acc <= sadd(r_acc, w_prod);
                qspid_pkg::OP_DRIVE:
                    r_drive <= w_drive_sat[31:0];
                default: ;
            endcase
        end
    end

    assign o_stat.div_done = (r_dcnt == 7'd1);
    assign o_drive = r_drive;
    assign o_speed = r_speed;
    assign o_count = r_count;
endmodule
`default_nettype wire

[hw/rtl/quadrature_speed_pid.sv]
// ----------------------------------------------------------------------------
// quadrature_speed_pid
// Speed loop for one wheel: quadrature count plus Q16.16 PID.
// ----------------------------------------------------------------------------
// Input stream: tuser = command (0 pin sample, 1 control tick),
//   tdata[0] = phase_a, tdata[1] = phase_b, tdata[7:2] zero padding.
// Output stream: tdata = motor_drive[31:0], measured_speed[63:32],
//   position_count[95:64]. One result per item.
// A pin sample updates the count in the accept cycle and reaches the output
// register through the S_OUT state and the done flag. A tick runs a fixed
// sequence on a shared multiplier, a separate error-times-period multiply
// and two 80-step bit-serial divides.
// One item is in work at a time; s_axis_tready is high only while idle with
// the output register empty, so a new item waits until the last result is taken.
// The result sits in an output register until taken; a stall holds it and
// the block accepts no new item until it drains.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data. The user must write them only
// while idle; the block itself does not enforce this.
// Reset (i_rst_n low, synchronous) restores register defaults and clears
// count, phase, integral, last error, speed and drive.
// ----------------------------------------------------------------------------
`default_nettype none
module quadrature_speed_pid (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // phase_a, phase_b
    input  wire         s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // motor_drive, measured_speed, position_count
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);
    logic        r_dir;
    logic [31:0] r_dist, r_period;
    logic signed [31:0] r_setpt, r_kp, r_ki, r_kd;
    logic        r_ovalid;
    logic [95:0] r_odata;

    qspid_pkg::t_cmd  w_cmd;
    qspid_pkg::t_stat w_stat;
    logic w_busy, w_done, w_start;
    logic signed [31:0] w_drive, w_speed, w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0; r_dist <= 32'd65536; r_period <= 32'd6554;
            r_setpt <= '0; r_kp <= 32'sd65536; r_ki <= '0; r_kd <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qspid_pkg::REG_DIR:    r_dir    <= i_cfg_data[0];
                qspid_pkg::REG_DIST:   r_dist   <= i_cfg_data;
                qspid_pkg::REG_PERIOD: r_period <= i_cfg_data;
                qspid_pkg::REG_SETPT:  r_setpt  <= i_cfg_data;
                qspid_pkg::REG_KP:     r_kp     <= i_cfg_data;
                qspid_pkg::REG_KI:     r_ki     <= i_cfg_data;
                qspid_pkg::REG_KD:     r_kd     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept only when idle and output empty
    assign s_axis_tready = !w_busy && !r_ovalid && !w_done;
    assign w_start = s_axis_tvalid && s_axis_tready;

    // sample phases are consumed in the accept cycle, no input register needed
    qspid_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_tick(s_axis_tuser), .i_out_free(!r_ovalid), .i_stat(w_stat),
        .o_cmd(w_cmd), .o_busy(w_busy), .o_done(w_done)
    );

    qspid_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_pa(s_axis_tdata[0]), .i_pb(s_axis_tdata[1]), .i_dir(r_dir),
        .i_dist(r_dist), .i_period(r_period), .i_setpt(r_setpt),
        .i_kp(r_kp), .i_ki(r_ki), .i_kd(r_kd),
        .o_drive(w_drive), .o_speed(w_speed), .o_count(w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_odata <= {w_count, w_speed, w_drive};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_ovalid)
        else $error("result overwritten");
endmodule
`default_nettype wire
